// ===== hdl/dbpm_pkg.sv =====
// ----------------------------------------------------------------------------
// dbpm_pkg
// Shared types, character codes and helpers for the dot-bracket pair matcher.
// ----------------------------------------------------------------------------
package dbpm_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned POS_W  = 12;
  // widest stack address over the legal column range
  localparam int unsigned ADDR_W = 16;

  localparam logic [CHAR_W-1:0] CH_OPEN_PAREN  = 8'h28;  // (
  localparam logic [CHAR_W-1:0] CH_CLOSE_PAREN = 8'h29;  // )
  localparam logic [CHAR_W-1:0] CH_OPEN_ANGLE  = 8'h3C;  // <
  localparam logic [CHAR_W-1:0] CH_CLOSE_ANGLE = 8'h3E;  // >
  localparam logic [CHAR_W-1:0] CH_OPEN_BRACE  = 8'h7B;  // {
  localparam logic [CHAR_W-1:0] CH_CLOSE_BRACE = 8'h7D;  // }
  localparam logic [CHAR_W-1:0] CH_A           = 8'h41;
  localparam logic [CHAR_W-1:0] CH_C           = 8'h43;
  localparam logic [CHAR_W-1:0] CH_G           = 8'h47;
  localparam logic [CHAR_W-1:0] CH_U           = 8'h55;

  typedef enum logic [1:0] {
    ST_KEPT       = 2'd0,
    ST_REJECTED   = 2'd1,
    ST_UNBALANCED = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_UNBAL = 2'd2,
    OP_OVF   = 2'd3
  } op_kind_e;

  // one classified column handed from front to back
  typedef struct packed {
    op_kind_e           kind;
    logic [ADDR_W-1:0]  addr;
    logic [POS_W-1:0]   pos;
    logic [CHAR_W-1:0]  base;
  } op_t;

  typedef struct packed {
    logic [POS_W-1:0] open_pos;
    logic [POS_W-1:0] close_pos;
    status_e          status;
  } res_t;

  function automatic logic is_opener(input logic [CHAR_W-1:0] c);
    return (c == CH_OPEN_PAREN) || (c == CH_OPEN_ANGLE) || (c == CH_OPEN_BRACE);
  endfunction

  function automatic logic is_closer(input logic [CHAR_W-1:0] c);
    return (c == CH_CLOSE_PAREN) || (c == CH_CLOSE_ANGLE) || (c == CH_CLOSE_BRACE);
  endfunction

  // a: closing base, b: opening base
  function automatic logic bases_pair(input logic [CHAR_W-1:0] a,
                                      input logic [CHAR_W-1:0] b);
    return (((a == CH_A) || (a == CH_G)) && (b == CH_U)) ||
           ((a == CH_U) && ((b == CH_A) || (b == CH_G))) ||
           ((a == CH_G) && (b == CH_C)) ||
           ((a == CH_C) && (b == CH_G));
  endfunction

endpackage

// ===== hdl/dbpm_fifo.sv =====
// ----------------------------------------------------------------------------
// dbpm_fifo
// Small register queue with full/empty flags, used between pipeline parts.
// ----------------------------------------------------------------------------
module dbpm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/dbpm_front.sv =====
// ----------------------------------------------------------------------------
// dbpm_front
// Classifies each column, tracks column index and stack depth, and issues
// push / pop / error operations to the back end.
// ----------------------------------------------------------------------------
module dbpm_front import dbpm_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [CHAR_W-1:0] struct_char_i,
  input  logic [CHAR_W-1:0] base_char_i,
  input  logic              last_i,
  input  logic              op_full_i,
  output logic              op_push_o,
  output op_t               op_o
);

  localparam int unsigned DW = $clog2(MAX_COLUMNS + 1);

  logic [DW-1:0]        col_q, col_d;
  logic [DW-1:0]        depth_q, depth_d;
  logic [DW-1:0]        stack_idx;
  logic [DW+POS_W-1:0]  col_ext;
  logic [DW+ADDR_W-1:0] idx_ext;
  logic                 opener, closer, ovf, accept;

  assign opener  = is_opener(struct_char_i);
  assign closer  = is_closer(struct_char_i);
  // column counter saturates at MAX_COLUMNS
  assign ovf     = (col_q == DW'(MAX_COLUMNS));
  assign accept  = push_i && !op_full_i;

  assign stack_idx = opener ? depth_q : depth_q - 1'b1;
  assign col_ext   = {{POS_W{1'b0}}, col_q};
  assign idx_ext   = {{ADDR_W{1'b0}}, stack_idx};

  assign op_push_o = accept && (opener || closer);

  always_comb begin
    op_o.addr = idx_ext[ADDR_W-1:0];
    op_o.pos  = col_ext[POS_W-1:0];
    op_o.base = base_char_i;
    priority if (ovf) begin
      op_o.kind = OP_OVF;
    end else if (opener) begin
      op_o.kind = OP_PUSH;
    end else if (depth_q == '0) begin
      op_o.kind = OP_UNBAL;
    end else begin
      op_o.kind = OP_POP;
    end
  end

  always_comb begin
    col_d   = col_q;
    depth_d = depth_q;
    if (accept) begin
      if (!ovf) begin
        col_d = col_q + 1'b1;
      end
      // depth never exceeds the column count, so a push always fits
      if (op_push_o && (op_o.kind == OP_PUSH)) begin
        depth_d = depth_q + 1'b1;
      end else if (op_push_o && (op_o.kind == OP_POP)) begin
        depth_d = depth_q - 1'b1;
      end
      if (last_i) begin
        col_d   = '0;
        depth_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      depth_q <= '0;
    end else begin
      col_q   <= col_d;
      depth_q <= depth_d;
    end
  end

endmodule

// ===== hdl/dbpm_back.sv =====
// ----------------------------------------------------------------------------
// dbpm_back
// Holds the open-bracket stack memory, executes pushes and pops, checks base
// compatibility and forms the result word.
// ----------------------------------------------------------------------------
module dbpm_back import dbpm_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 4096
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  logic  cfg_wdata_i,
  input  logic  op_empty_i,
  input  op_t   op_i,
  output logic  op_pop_o,
  input  logic  res_full_i,
  output logic  res_push_o,
  output res_t  res_o
);

  localparam int unsigned AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic [POS_W+CHAR_W-1:0] stack_mem [MAX_COLUMNS];
  logic [POS_W+CHAR_W-1:0] rd_q;
  logic                    check_q;
  logic                    s1_valid_q;
  op_kind_e                s1_kind_q;
  logic [POS_W-1:0]        s1_pos_q;
  logic [CHAR_W-1:0]       s1_base_q;
  logic [POS_W-1:0]        top_pos;
  logic [CHAR_W-1:0]       top_base;
  logic                    res_valid, advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_q <= 1'b1;
    end else if (cfg_we_i) begin
      check_q <= cfg_wdata_i;
    end
  end

  assign res_valid = s1_valid_q && (s1_kind_q != OP_PUSH);
  // hold the result stage while the output queue cannot take its word
  assign advance   = !(res_valid && res_full_i);
  assign op_pop_o  = !op_empty_i && advance;
  assign res_push_o = res_valid && !res_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= op_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      s1_kind_q <= op_i.kind;
      s1_pos_q  <= op_i.pos;
      s1_base_q <= op_i.base;
    end
  end

  // one access per word: write on push, registered read on pop
  always_ff @(posedge clk_i) begin
    if (op_pop_o && (op_i.kind == OP_PUSH)) begin
      stack_mem[op_i.addr[AW-1:0]] <= {op_i.pos, op_i.base};
    end
    if (op_pop_o && (op_i.kind == OP_POP)) begin
      rd_q <= stack_mem[op_i.addr[AW-1:0]];
    end
  end

  assign top_pos  = rd_q[POS_W+CHAR_W-1:CHAR_W];
  assign top_base = rd_q[CHAR_W-1:0];

  always_comb begin
    res_o.close_pos = s1_pos_q;
    res_o.open_pos  = '0;
    unique case (s1_kind_q)
      OP_POP: begin
        res_o.open_pos = top_pos;
        res_o.status   = (!check_q || bases_pair(s1_base_q, top_base)) ?
                         ST_KEPT : ST_REJECTED;
      end
      OP_UNBAL: res_o.status = ST_UNBALANCED;
      OP_OVF:   res_o.status = ST_OVERFLOW;
      default:  res_o.status = ST_KEPT;
    endcase
  end

endmodule

// ===== hdl/dot_bracket_pair_matcher.sv =====
// ----------------------------------------------------------------------------
// dot_bracket_pair_matcher
// Matches dot-bracket structure columns into open/close position pairs.
//
//   channel   direction  handshake           payload
//   column    in         push / full         struct_char_i, base_char_i, last_i
//   pair      out        empty / pop         open_pos_o, close_pos_o, status_o
//   config    in         cfg_we_i            cfg_wdata_i (check_bases)
//
// One column is taken per cycle while full is low; a result passes through
// the operation queue, the registered read of the stack memory and the
// result queue on its way to the output. The stack memory needs no clearing
// pass: reset clears the counters, queues and result stage, not the memory.
// A stalled output fills the two-word result queue, then the operation queue, then raises full.
// ----------------------------------------------------------------------------
module dot_bracket_pair_matcher import dbpm_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              push,
  output logic              full,
  input  logic [CHAR_W-1:0] struct_char_i,
  input  logic [CHAR_W-1:0] base_char_i,
  input  logic              last_i,
  output logic              empty,
  input  logic              pop,
  output logic [POS_W-1:0]  open_pos_o,
  output logic [POS_W-1:0]  close_pos_o,
  output logic [1:0]        status_o
);

  localparam int unsigned QUEUE_DEPTH = 2;

  logic op_push, op_full, op_pop, op_empty;
  logic res_push, res_full;
  op_t  op_in, op_out;
  res_t res_in, res_out;

  dbpm_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .struct_char_i (struct_char_i),
    .base_char_i   (base_char_i),
    .last_i        (last_i),
    .op_full_i     (op_full),
    .op_push_o     (op_push),
    .op_o          (op_in)
  );

  // columns that are no bracket never enter the queue but are still refused while it is full
  assign full = op_full;

  dbpm_fifo #(.WIDTH($bits(op_t)), .DEPTH(QUEUE_DEPTH)) u_op_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .wdata_i (op_in),
    .full_o  (op_full),
    .pop_i   (op_pop),
    .rdata_o (op_out),
    .empty_o (op_empty)
  );

  dbpm_back #(.MAX_COLUMNS(MAX_COLUMNS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_empty_i  (op_empty),
    .op_i        (op_out),
    .op_pop_o    (op_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  dbpm_fifo #(.WIDTH($bits(res_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign open_pos_o  = res_out.open_pos;
  assign close_pos_o = res_out.close_pos;
  assign status_o    = res_out.status;

endmodule

// ===== hdl/dbpm_checker.sv =====
// ----------------------------------------------------------------------------
// dbpm_checker
// Port-level checks for the dot-bracket pair matcher, bound to the top level.
// ----------------------------------------------------------------------------
module dbpm_checker import dbpm_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 4096
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              push,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input logic [POS_W-1:0]  open_pos_o,
  input logic [POS_W-1:0]  close_pos_o,
  input logic [1:0]        status_o
);

  // reset drains both queues
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> (empty && !full))
    else $error("queues not drained in reset");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(open_pos_o) && $stable(close_pos_o)
                          && $stable(status_o)))
    else $error("result word changed while stalled");

  // error words carry no opening position
  a_err_open_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && ((status_o == ST_UNBALANCED) || (status_o == ST_OVERFLOW)))
    |-> (open_pos_o == '0))
    else $error("error word with opening position");

  // a matched opener lies before its closer
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((MAX_COLUMNS <= 4096) && !empty &&
     ((status_o == ST_KEPT) || (status_o == ST_REJECTED)))
    |-> (open_pos_o < close_pos_o))
    else $error("pair out of order");

endmodule

bind dot_bracket_pair_matcher dbpm_checker #(.MAX_COLUMNS(MAX_COLUMNS)) u_dbpm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .open_pos_o  (open_pos_o),
  .close_pos_o (close_pos_o),
  .status_o    (status_o)
);

// ===== sim/dbpm_pair_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dbpm_pair_checker
// Watches the column and pair channels of the dot-bracket pair matcher. It
// keeps its own bracket stack and column counter, predicts the pair word
// that each accepted column causes, and compares every accepted pair word
// field by field with the oldest prediction. Mismatches are counted for the
// testbench top.
// ----------------------------------------------------------------------------
module dbpm_pair_checker import dbpm_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              push_i,
  input  logic              full_i,
  input  logic [CHAR_W-1:0] struct_char_i,
  input  logic [CHAR_W-1:0] base_char_i,
  input  logic              last_i,
  input  logic              empty_i,
  input  logic              pop_i,
  input  logic [POS_W-1:0]  open_pos_i,
  input  logic [POS_W-1:0]  close_pos_i,
  input  logic [1:0]        status_i,
  output int                pairs_pending_o,
  output int                mismatches_o
);

  localparam int unsigned CNT_W = $clog2(MAX_COLUMNS) + 1;

  typedef enum logic [1:0] {
    COL_OPEN,
    COL_CLOSE,
    COL_PLAIN
  } col_kind_e;

  logic [POS_W-1:0]  open_at   [MAX_COLUMNS];
  logic [CHAR_W-1:0] open_base [MAX_COLUMNS];
  logic [CNT_W-1:0]  depth;
  logic [CNT_W-1:0]  column;
  logic              check_bases;
  res_t              pairs_due [$];

  function automatic col_kind_e classify(input logic [CHAR_W-1:0] c);
    case (c)
      CH_OPEN_PAREN, CH_OPEN_ANGLE, CH_OPEN_BRACE:    return COL_OPEN;
      CH_CLOSE_PAREN, CH_CLOSE_ANGLE, CH_CLOSE_BRACE: return COL_CLOSE;
      default:                                        return COL_PLAIN;
    endcase
  endfunction

  function automatic logic bases_match(input logic [CHAR_W-1:0] closing,
                                       input logic [CHAR_W-1:0] opening);
    case ({closing, opening})
      {CH_A, CH_U}, {CH_U, CH_A}, {CH_G, CH_C},
      {CH_C, CH_G}, {CH_G, CH_U}, {CH_U, CH_G}: return 1'b1;
      default:                                  return 1'b0;
    endcase
  endfunction

  task automatic track_column(input logic [CHAR_W-1:0] sc,
                              input logic [CHAR_W-1:0] bc,
                              input logic              lst);
    res_t      pair;
    col_kind_e kind;
    kind = classify(sc);
    pair.open_pos  = '0;
    pair.close_pos = column[POS_W-1:0];
    pair.status    = ST_KEPT;
    if (kind != COL_PLAIN) begin
      if (column >= MAX_COLUMNS) begin
        pair.status = ST_OVERFLOW;
        pairs_due.push_back(pair);
      end else if (kind == COL_OPEN) begin
        if (depth < MAX_COLUMNS) begin
          open_at[depth]   = column[POS_W-1:0];
          open_base[depth] = bc;
          depth++;
        end
      end else if (depth == 0) begin
        pair.status = ST_UNBALANCED;
        pairs_due.push_back(pair);
      end else begin
        depth--;
        pair.open_pos = open_at[depth];
        if (check_bases && !bases_match(bc, open_base[depth])) pair.status = ST_REJECTED;
        pairs_due.push_back(pair);
      end
    end
    // the counter saturates one past the last legal column
    if (column < MAX_COLUMNS) column++;
    if (lst) begin
      depth  = '0;
      column = '0;
    end
  endtask

  task automatic report_field(input string what, input logic [POS_W-1:0] want,
                              input logic [POS_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    res_t want;
    if (!rst_ni) begin
      depth       = '0;
      column      = '0;
      check_bases = 1'b1;
      pairs_due.delete();
    end else begin
      if (pop_i && !empty_i) begin
        if (pairs_due.size() == 0) begin
          $display("%0t ns: unexpected pair word, expected none, actual %0d/%0d/%0d",
                   $time, open_pos_i, close_pos_i, status_i);
          mismatches_o++;
        end else begin
          want = pairs_due.pop_front();
          report_field("open_pos", want.open_pos, open_pos_i);
          report_field("close_pos", want.close_pos, close_pos_i);
          report_field("status", POS_W'(want.status), POS_W'(status_i));
        end
      end
      if (cfg_we_i) check_bases = cfg_wdata_i;
      if (push_i && !full_i) track_column(struct_char_i, base_char_i, last_i);
    end
    pairs_pending_o = pairs_due.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the dot-bracket pair matcher: directed columns for each bracket
// kind, base pairing and error case, one long sequence that runs past the
// column limit, then random sequences under random idling, a long output
// stall and a stretch at full rate. The checker beside the block predicts
// and compares; this module drives the channels and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import dbpm_pkg::*;

  localparam int unsigned MAX_COLUMNS = 4096;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          RANDOM_ITEMS = 2000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic              cfg_wdata;
  logic              push;
  logic              full;
  logic [CHAR_W-1:0] struct_char;
  logic [CHAR_W-1:0] base_char;
  logic              last;
  logic              empty;
  logic              pop;
  logic [POS_W-1:0]  open_pos;
  logic [POS_W-1:0]  close_pos;
  logic [1:0]        status;
  int                pairs_pending;
  int                mismatches;

  bit                no_idle;
  bit                hold_req;
  int                items_sent;
  int                quiet_cycles;

  dot_bracket_pair_matcher #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .push         (push),
    .full         (full),
    .struct_char_i(struct_char),
    .base_char_i  (base_char),
    .last_i       (last),
    .empty        (empty),
    .pop          (pop),
    .open_pos_o   (open_pos),
    .close_pos_o  (close_pos),
    .status_o     (status)
  );

  dbpm_pair_checker #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .push_i         (push),
    .full_i         (full),
    .struct_char_i  (struct_char),
    .base_char_i    (base_char),
    .last_i         (last),
    .empty_i        (empty),
    .pop_i          (pop),
    .open_pos_i     (open_pos),
    .close_pos_i    (close_pos),
    .status_i       (status),
    .pairs_pending_o(pairs_pending),
    .mismatches_o   (mismatches)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // ---- character pickers ----

  function automatic logic [CHAR_W-1:0] pick_base();
    logic [CHAR_W-1:0] nuc;
    int                r;
    r = $urandom_range(0, 19);
    case (r % 4)
      0:       nuc = CH_A;
      1:       nuc = CH_U;
      2:       nuc = CH_G;
      default: nuc = CH_C;
    endcase
    if (r < 17) return nuc;
    if (r == 17) return nuc | 8'h20;  // lower case never pairs
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CHAR_W-1:0] pick_open();
    case ($urandom_range(0, 2))
      0:       return CH_OPEN_PAREN;
      1:       return CH_OPEN_ANGLE;
      default: return CH_OPEN_BRACE;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_close();
    case ($urandom_range(0, 2))
      0:       return CH_CLOSE_PAREN;
      1:       return CH_CLOSE_ANGLE;
      default: return CH_CLOSE_BRACE;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_plain();
    case ($urandom_range(0, 7))
      0, 1, 2: return ".";
      3:       return ":";
      4:       return "-";
      5:       return ",";
      6:       return 8'h00;
      default: return 8'hFF;
    endcase
  endfunction

  // ---- channel tasks ----

  task automatic send_column(input logic [CHAR_W-1:0] sc, input logic [CHAR_W-1:0] bc,
                             input logic lst);
    if (!no_idle && $urandom_range(0, 99) < 32) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    push        <= 1'b1;
    struct_char <= sc;
    base_char   <= bc;
    last        <= lst;
    do @(negedge clk_i); while (full);
    @(posedge clk_i);
    items_sent++;
  endtask

  // hold input until every predicted pair word is out, then let opening
  // columns still in the pipeline pass
  task automatic drain();
    push <= 1'b0;
    do @(negedge clk_i); while (pairs_pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_check(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic play_sequence();
    int          len;
    int          depth;
    int          rem;
    bit          noisy;
    logic        lst;
    logic [CHAR_W-1:0] sc;
    noisy = ($urandom_range(0, 9) == 0);
    len   = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
    depth = 0;
    for (int i = 0; i < len; i++) begin
      rem = len - i;
      lst = (rem == 1) && (!noisy || $urandom_range(0, 3) != 0);
      if (noisy) begin
        case ($urandom_range(0, 3))
          0:       sc = CHAR_W'($urandom_range(0, 255));
          1:       sc = pick_open();
          2:       sc = pick_close();
          default: sc = pick_plain();
        endcase
      end else if (depth >= rem) begin
        sc = pick_close();
        depth--;
      end else begin
        case ($urandom_range(0, 2))
          0:       sc = (depth + 1 < rem) ? pick_open() : pick_plain();
          1:       sc = (depth > 0) ? pick_close() : pick_plain();
          default: sc = pick_plain();
        endcase
        if (sc inside {CH_OPEN_PAREN, CH_OPEN_ANGLE, CH_OPEN_BRACE}) depth++;
        if (sc inside {CH_CLOSE_PAREN, CH_CLOSE_ANGLE, CH_CLOSE_BRACE}) depth--;
      end
      send_column(sc, pick_base(), lst);
    end
  endtask

  // ---- receiver ----

  initial begin
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else begin
        pop <= no_idle || ($urandom_range(0, 99) >= 32);
      end
    end
  end

  // ---- watchdog ----

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t ns: no word moved for %0d cycles", $time, QUIET_LIMIT);
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // ---- stimulus ----

  initial begin
    int  random_start;
    int  phase;
    bit  held;
    rst_ni      <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= 1'b0;
    push        <= 1'b0;
    struct_char <= '0;
    base_char   <= '0;
    last        <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // base checking on from reset
    send_column(CH_CLOSE_PAREN, CH_A, 1'b0);  // close on empty stack
    send_column(CH_OPEN_PAREN, CH_G, 1'b0);
    send_column(CH_OPEN_ANGLE, CH_A, 1'b0);
    send_column(CH_OPEN_BRACE, CH_U, 1'b0);
    send_column(".", 8'hFF, 1'b0);
    send_column(CH_CLOSE_BRACE, CH_A, 1'b0);
    send_column(CH_CLOSE_ANGLE, CH_U, 1'b0);
    send_column(CH_CLOSE_PAREN, CH_C, 1'b0);
    send_column(CH_OPEN_PAREN, "a", 1'b0);
    send_column(CH_CLOSE_PAREN, "u", 1'b0);   // case-sensitive: rejected
    send_column(CH_OPEN_PAREN, CH_G, 1'b0);
    send_column(CH_CLOSE_PAREN, CH_U, 1'b0);
    send_column(CH_OPEN_PAREN, CH_U, 1'b0);
    send_column(CH_CLOSE_ANGLE, CH_G, 1'b0);  // mixed bracket kinds still pair
    send_column(CH_OPEN_BRACE, CH_C, 1'b0);
    send_column(CH_CLOSE_PAREN, CH_G, 1'b0);
    send_column(CH_OPEN_PAREN, CH_A, 1'b0);
    send_column(CH_CLOSE_BRACE, CH_A, 1'b0);
    send_column(8'h00, 8'h00, 1'b0);
    send_column(8'hFF, 8'hFF, 1'b0);
    send_column(CH_OPEN_PAREN, CH_G, 1'b0);
    send_column(CH_OPEN_PAREN, CH_C, 1'b1);   // drop open brackets at the end
    send_column(CH_CLOSE_ANGLE, CH_U, 1'b1);
    drain();
    set_check(1'b0);
    send_column(CH_OPEN_PAREN, CH_A, 1'b0);
    send_column(CH_CLOSE_PAREN, CH_A, 1'b1);
    drain();
    set_check(1'b1);

    // one sequence past the column limit: deep stack, top positions, overflow
    for (int i = 0; i < MAX_COLUMNS + 40; i++) begin
      if (i < 2047 || i == MAX_COLUMNS - 2) begin
        send_column(pick_open(), pick_base(), 1'b0);
      end else if (i < MAX_COLUMNS) begin
        send_column(pick_close(), pick_base(), 1'b0);
      end else begin
        case ($urandom_range(0, 2))
          0:       send_column(pick_open(), pick_base(), i == MAX_COLUMNS + 39);
          1:       send_column(pick_close(), pick_base(), i == MAX_COLUMNS + 39);
          default: send_column(pick_plain(), pick_base(), i == MAX_COLUMNS + 39);
        endcase
      end
    end

    random_start = items_sent;
    phase = 0;
    held  = 1'b0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      play_sequence();
      if (items_sent - random_start >= (phase + 1) * 400) begin
        phase++;
        drain();
        set_check((phase == 4) ? 1'($urandom_range(0, 1)) : phase[0]);
      end
      if (!held && items_sent - random_start >= 800) begin
        // stall the output while pairs keep coming so the block backs up
        held     = 1'b1;
        hold_req = 1'b1;
        for (int k = 0; k < 60; k++) begin
          send_column(pick_open(), pick_base(), 1'b0);
          send_column(pick_close(), pick_base(), k == 59);
        end
      end
      no_idle = (items_sent - random_start >= 1200) && (items_sent - random_start < 1500);
    end

    no_idle = 1'b0;
    drain();
    repeat (8) @(posedge clk_i);
    if (pairs_pending != 0) $display("%0t ns: %0d pair words never arrived", $time, pairs_pending);
    if (mismatches == 0 && pairs_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dbpm_pkg.sv
hdl/dbpm_fifo.sv
hdl/dbpm_front.sv
hdl/dbpm_back.sv
hdl/dot_bracket_pair_matcher.sv
hdl/dbpm_checker.sv
sim/dbpm_pair_checker.sv
sim/tb.sv
